// File: rtl/core/led_strip_effect_generator_assert.svh
// ----------------------------------------------------------------------------
// LED strip effect generator assertion macros
// Shared property forms for the design checks of the effect generator.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_EFFECT_GENERATOR_ASSERT_SVH
`define LED_STRIP_EFFECT_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define LSEG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LSEG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lseg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lseg_pkg
// Shared types, codes and constant tables of the LED strip effect generator.
// ----------------------------------------------------------------------------
package lseg_pkg;

  // Largest strip the block drives
  localparam logic [6:0] MAX_LEDS = 7'd64;

  // Effect codes; codes 6 and 7 select no effect
  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_SOLID  = 3'd1,
    MODE_FADE   = 3'd2,
    MODE_BREATH = 3'd3,
    MODE_CHASE  = 3'd4,
    MODE_STROBE = 3'd5
  } effect_mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_RED    = 3'd1,
    CFG_GREEN  = 3'd2,
    CFG_BLUE   = 3'd3,
    CFG_SPEED  = 3'd4,
    CFG_LENGTH = 3'd5
  } cfg_reg_t;

  // One frame request from the control stage to the frame emitter
  typedef struct packed {
    logic [6:0] len;     // LEDs in the frame, 1..MAX_LEDS
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       single;  // only the LED at lit carries the colour
    logic [5:0] lit;
  } frame_req_t;

  typedef logic [255:0][7:0] breath_lut_t;
  typedef logic [255:0][8:0] interval_lut_t;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin((pi/2)*r/255) in Q30, Taylor series; evaluated at elaboration only
  function automatic logic [63:0] sine_quarter(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    int          n;
    x    = (HALF_PI_Q30 * r + 64'd127) / 64'd255;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (n = 1; n <= 12; n++) begin
      term = (term * x2) >> 30;
      // Divide by (2n)(2n+1) for this term of the series
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        9:       term = term / 64'd342;
        10:      term = term / 64'd420;
        11:      term = term / 64'd506;
        default: term = term / 64'd600;
      endcase
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    return sum;
  endfunction

  // Breathing brightness: floor(127.5*(1+sin(2*pi*k/255)))
  function automatic breath_lut_t build_breath_lut();
    breath_lut_t lut;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] base;
    logic [63:0] v;
    int          k;
    for (k = 0; k < 256; k++) begin
      m    = 64'(4 * k);
      q    = (m / 64'd255) & 64'd3;
      r    = m % 64'd255;
      s    = q[0] ? sine_quarter(64'd255 - r) : sine_quarter(r);
      base = (q >= 64'd2) ? (Q30_ONE - s) : (Q30_ONE + s);
      v    = (64'd255 * base) >> 31;
      if (v > 64'd255) begin
        v = 64'd255;
      end
      lut[k] = v[7:0];
    end
    return lut;
  endfunction

  // Update interval in ms per speed level; level zero behaves as level one
  function automatic interval_lut_t build_interval_lut();
    interval_lut_t lut;
    int            sp;
    int            s;
    for (s = 0; s < 256; s++) begin
      sp     = (s == 0) ? 1 : s;
      lut[s] = 9'(500 - ((sp - 1) * 498) / 254);
    end
    return lut;
  endfunction

  localparam breath_lut_t   BREATH_LUT   = build_breath_lut();
  localparam interval_lut_t INTERVAL_LUT = build_interval_lut();

endpackage
`default_nettype wire

// File: rtl/core/led_strip_effect_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// LED strip effect generator.
// Input channel (in_valid / in_stall / in_now_ms): one millisecond timestamp
// per request. Each request is checked against the selected effect and timer;
// when an update is due it produces one frame: one result per LED, in LED
// order, on the output channel (out_valid / out_stall / out_led_index,
// out_red, out_green, out_blue, out_last_led), out_last_led marking the end.
// A request that is not due produces nothing and retires without stalling.
// A due request passes the input register and the frame register, and its
// first LED the output register. A chase request made after the strip was
// shortened first holds while its phase folds down by the strip length into
// the strip. Throughput: one LED per cycle while out_stall is low, set by the
// single output register; frames follow back to back and the next timestamp
// is taken while the current frame is still draining. Stall: a stalled output
// holds its LED; the emitter and then the input register fill, and in_stall
// rises until the output moves again. Reset (rst_n low at a clock edge): mode
// none, colour black, speed 1, strip length 0, phase and timer zero, no
// results pending. Configuration: cfg_we writes cfg_wdata to register
// cfg_index while idle; the user keeps to it, the block does not enforce it.
// ----------------------------------------------------------------------------
// led_strip_effect_generator
// Top level: control and decision stage feeding the per-LED frame emitter.
// ----------------------------------------------------------------------------
module led_strip_effect_generator import lseg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_led_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last_led,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic       req_vld;
  frame_req_t req;
  logic       frame_ready;

  // Decide effect and colour per request
  lseg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_now_ms   (in_now_ms),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req_vld     (req_vld),
    .req         (req),
    .frame_ready (frame_ready)
  );

  // Emit the frame one LED per cycle while the output is not stalled
  lseg_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_vld       (req_vld),
    .req           (req),
    .frame_ready   (frame_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_led  (out_last_led)
  );

endmodule
`default_nettype wire

// File: rtl/core/lseg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lseg_ctrl
// Configuration registers, timestamp input register and the effect decision:
// timer check, phase advance and per-frame colour, issued as a frame request.
// ----------------------------------------------------------------------------
module lseg_ctrl import lseg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  output logic             req_vld,
  output frame_req_t       req,
  input  wire logic        frame_ready
);

  logic [2:0]  mode_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  speed_r;
  logic [6:0]  strip_r;
  logic [8:0]  phase_r;
  logic [8:0]  phase_nxt;
  logic [31:0] last_ms_r;
  logic [31:0] last_ms_nxt;
  logic        in_vld_r;
  logic        in_vld_nxt;
  logic [31:0] now_r;

  logic [6:0]  len_sat;
  logic        mode_ok;
  logic [31:0] elapsed;
  logic        due;
  logic        emit;
  logic        consume;
  logic        accept;
  logic        chase_fold;
  logic        fold_step;
  logic [5:0]  chase_pos;
  logic [8:0]  chase_next;
  logic [7:0]  bright;
  logic [8:0]  bright_p1;
  logic [16:0] prod_red;
  logic [16:0] prod_green;
  logic [16:0] prod_blue;

  // Decide whether the held request produces a frame
  assign len_sat = (strip_r > MAX_LEDS) ? MAX_LEDS : strip_r;
  assign mode_ok = mode_r inside {[MODE_SOLID:MODE_STROBE]};
  assign elapsed = now_r - last_ms_r;
  assign due     = elapsed >= {23'd0, INTERVAL_LUT[speed_r]};
  assign emit    = (len_sat != 7'd0) && mode_ok &&
                   ((mode_r == MODE_SOLID) ? (phase_r == 9'd0) : due);

  // Chase phase at or past the strip end: fold it down one length per cycle while a due request waits
  assign chase_fold = (mode_r == MODE_CHASE) && (phase_r >= {2'd0, len_sat});
  assign fold_step  = in_vld_r && emit && chase_fold;

  // Retire the request when it needs no frame or the emitter can take one and no chase fold is pending
  assign consume  = in_vld_r && (!emit || (frame_ready && !chase_fold));
  assign in_stall = in_vld_r && !consume;
  assign accept   = in_valid && !in_stall;
  assign req_vld  = consume && emit;

  // Chase position (phase already below the strip length) and its successor
  assign chase_pos  = phase_r[5:0];
  assign chase_next = ({1'b0, chase_pos} + 7'd1 == len_sat) ? 9'd0
                                                            : {3'd0, chase_pos} + 9'd1;

  // Brightness for the scaled effects
  always_comb begin
    case (mode_r)
      MODE_FADE:   bright = phase_r[8] ? ~phase_r[7:0] : phase_r[7:0];
      MODE_BREATH: bright = BREATH_LUT[phase_r[7:0]];
      default:     bright = 8'd0;
    endcase
  end

  assign bright_p1  = {1'b0, bright} + 9'd1;
  assign prod_red   = 17'(red_r) * 17'(bright_p1);
  assign prod_green = 17'(green_r) * 17'(bright_p1);
  assign prod_blue  = 17'(blue_r) * 17'(bright_p1);

  // Build the frame request
  always_comb begin
    req.len    = len_sat;
    req.red    = red_r;
    req.green  = green_r;
    req.blue   = blue_r;
    req.single = 1'b0;
    req.lit    = 6'd0;
    case (mode_r)
      MODE_FADE, MODE_BREATH: begin
        req.red   = prod_red[15:8];
        req.green = prod_green[15:8];
        req.blue  = prod_blue[15:8];
      end
      MODE_CHASE: begin
        req.single = 1'b1;
        req.lit    = chase_pos;
      end
      MODE_STROBE: begin
        if (phase_r[0]) begin
          req.red   = 8'd0;
          req.green = 8'd0;
          req.blue  = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Fold the chase phase; advance phase and timer on an emitted frame; a mode write clears the phase
  always_comb begin
    phase_nxt   = phase_r;
    last_ms_nxt = last_ms_r;
    if (fold_step) begin
      phase_nxt = phase_r - {2'd0, len_sat};
    end
    if (req_vld) begin
      case (mode_r)
        MODE_SOLID:  phase_nxt = 9'd1;
        MODE_FADE:   phase_nxt = phase_r + 9'd3;
        MODE_BREATH: phase_nxt = {1'b0, phase_r[7:0] + 8'd1};
        MODE_CHASE:  phase_nxt = chase_next;
        MODE_STROBE: phase_nxt = phase_r + 9'd1;
        default:     phase_nxt = phase_r;
      endcase
      if (mode_r != MODE_SOLID) begin
        last_ms_nxt = now_r;
      end
    end
    if (cfg_we && (cfg_index == CFG_MODE)) begin
      phase_nxt = 9'd0;
    end
  end

  // Hold one request in the input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NONE;
      red_r     <= 8'd0;
      green_r   <= 8'd0;
      blue_r    <= 8'd0;
      speed_r   <= 8'd1;
      strip_r   <= 7'd0;
      phase_r   <= 9'd0;
      last_ms_r <= 32'd0;
      in_vld_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      last_ms_r <= last_ms_nxt;
      in_vld_r  <= in_vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   mode_r  <= cfg_wdata[2:0];
          CFG_RED:    red_r   <= cfg_wdata;
          CFG_GREEN:  green_r <= cfg_wdata;
          CFG_BLUE:   blue_r  <= cfg_wdata;
          CFG_SPEED:  speed_r <= cfg_wdata;
          CFG_LENGTH: strip_r <= cfg_wdata[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Capture the timestamp payload
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now_ms;
    end
  end

  `include "led_strip_effect_generator_assert.svh"

  `LSEG_ASSERT_NOW(a_req_needs_room, req_vld, frame_ready,
                   "frame request issued while the emitter is busy")
  `LSEG_ASSERT_NEXT(a_chase_in_strip, req_vld && (mode_r == MODE_CHASE),
                    (phase_r < {2'd0, $past(len_sat)}),
                    "chase phase left the strip")

endmodule
`default_nettype wire

// File: rtl/core/lseg_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lseg_frame
// Frame emitter: walks the LEDs of one frame request and presents one LED
// colour per cycle through the output register while out_stall is low.
// ----------------------------------------------------------------------------
module lseg_frame import lseg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       req_vld,
  input  wire frame_req_t req,
  output logic            frame_ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [5:0]      out_led_index,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic            out_last_led
);

  logic       active_r;
  logic       active_nxt;
  frame_req_t frm_r;
  logic [5:0] idx_r;
  logic [5:0] idx_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       out_free;
  logic       issue;
  logic       last_issue;
  logic       lit_on;
  logic       load;

  // Issue one LED whenever the output register frees up
  assign out_free    = !out_vld_r || !out_stall;
  assign issue       = active_r && out_free;
  assign last_issue  = issue && ({1'b0, idx_r} + 7'd1 == frm_r.len);
  assign frame_ready = !active_r || last_issue;
  assign load        = req_vld && frame_ready;
  assign lit_on      = !frm_r.single || (idx_r == frm_r.lit);

  // Advance through the frame
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (load) begin
      active_nxt = 1'b1;
      idx_nxt    = 6'd0;
    end else if (last_issue) begin
      active_nxt = 1'b0;
    end else if (issue) begin
      idx_nxt = idx_r + 6'd1;
    end
  end

  // Fill or drain the output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (issue) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      idx_r     <= 6'd0;
      out_vld_r <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold frame parameters and result payload
  always_ff @(posedge clk) begin
    if (load) begin
      frm_r <= req;
    end
    if (issue) begin
      out_led_index <= idx_r;
      out_red       <= lit_on ? frm_r.red : 8'd0;
      out_green     <= lit_on ? frm_r.green : 8'd0;
      out_blue      <= lit_on ? frm_r.blue : 8'd0;
      out_last_led  <= last_issue;
    end
  end

  assign out_valid = out_vld_r;

  `include "led_strip_effect_generator_assert.svh"

  `LSEG_ASSERT_NOW(a_idx_in_frame, active_r,
                   ({1'b0, idx_r} < frm_r.len) && (frm_r.len <= MAX_LEDS),
                   "LED index outside the frame")
  `LSEG_ASSERT_NEXT(a_idx_steps, issue && !last_issue && !load,
                    active_r && (idx_r == $past(idx_r) + 6'd1),
                    "LED index did not advance by one")

endmodule
`default_nettype wire
